// ===== sv/lfc_pkg.sv =====
// shared types, sizes and the slot choice function for the font choice cache
// no dependencies; compiled first
package lfc_pkg;

    localparam int CACHE_ENTRIES = 64;
    localparam int FONT_SLOTS    = 16;
    localparam int KEY_W         = 21;
    localparam int MASK_W        = 16;
    localparam int SLOT_W        = 4;
    localparam int AGE_W         = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 4;

    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(CACHE_ENTRIES - 1);

    localparam logic [CFG_IDX_W-1:0] REG_PRIMARY_VALID  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_COUNT = CFG_IDX_W'(1);

    // broadcast to every entry
    typedef struct packed {
        logic             clear;
        logic             upd;
        logic             hit;
        logic [AGE_W-1:0] hit_age;
        logic [KEY_W-1:0] key;
        logic [SLOT_W-1:0] slot;
    } lfc_cmd_t;

    // what each entry reports back
    typedef struct packed {
        logic              valid;
        logic              match;
        logic              oldest;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] slot;
        logic [AGE_W-1:0]  age;
    } lfc_stat_t;

    function automatic logic [SLOT_W-1:0] choose_slot(
        input logic              primary_valid,
        input logic [SLOT_W-1:0] fallback_count,
        input logic [MASK_W-1:0] mask
    );
        logic [SLOT_W-1:0] pick;
        pick = '0;
        // scan from the top so the lowest eligible fallback wins
        for (int i = MASK_W - 1; i >= 1; i--)
        begin
            if (i < FONT_SLOTS && SLOT_W'(i) <= fallback_count && mask[i])
            begin
                pick = SLOT_W'(i);
            end
        end
        if (primary_valid && mask[0])
        begin
            pick = '0;
        end
        return pick;
    endfunction

endpackage

// ===== sv/lfc_cell.sv =====
// one cache entry: key, slot, valid and age registers with its tag compare
// depends on lfc_pkg
module lfc_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  lfc_pkg::lfc_cmd_t cmd,
    input  logic              sel,
    output lfc_pkg::lfc_stat_t stat
);
    import lfc_pkg::*;

    logic [KEY_W-1:0]  key_reg, key_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              valid_reg, valid_next;
    logic [AGE_W-1:0]  age_reg, age_next;

    assign stat.valid  = valid_reg;
    assign stat.match  = valid_reg && (key_reg == cmd.key);
    assign stat.oldest = valid_reg && (age_reg == AGE_MAX);
    assign stat.key    = key_reg;
    assign stat.slot   = slot_reg;
    assign stat.age    = age_reg;

    always_comb
    begin
        key_next   = key_reg;
        slot_next  = slot_reg;
        valid_next = valid_reg;
        age_next   = age_reg;
        if (cmd.clear)
        begin
            valid_next = 1'b0;
            age_next   = '0;
        end
        else if (cmd.upd)
        begin
            if (cmd.hit)
            begin
                if (stat.match)
                begin
                    age_next = '0;
                end
                else if (valid_reg && age_reg < cmd.hit_age)
                begin
                    age_next = age_reg + 1'b1;
                end
            end
            else if (sel)
            begin
                key_next   = cmd.key;
                slot_next  = cmd.slot;
                valid_next = 1'b1;
                age_next   = '0;
            end
            else if (valid_reg)
            begin
                age_next = age_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            age_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            age_reg   <= age_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        slot_reg <= slot_next;
    end

endmodule

// ===== sv/lru_font_choice_cache.sv =====
// top level of the font choice cache: input register, entry array, result register
// depends on lfc_pkg and lfc_cell
//
// Fully associative LRU cache from a 21-bit code point to a font slot. A word is
// taken into an input register; once the result register can take it, all entries
// compare their keys in parallel, ages are updated and the result register is
// loaded, so one word is accepted every cycle while out_stall does not hold the
// result. The tag compare and age update across the entry array set this rate.
// On a miss the lowest free entry is filled, or the entry with the highest age
// is replaced once all are in use. Writing either config register invalidates
// all entries at once; no clearing pass is needed.
module lru_font_choice_cache (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [lfc_pkg::KEY_W-1:0]      codepoint,
    input  logic [lfc_pkg::MASK_W-1:0]     support_mask,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [lfc_pkg::SLOT_W-1:0]     font_slot,
    output logic                           is_primary,
    output logic                           hit,
    output logic                           evicted,
    output logic [lfc_pkg::KEY_W-1:0]      evicted_codepoint,
    input  logic                           cfg_we,
    input  logic [lfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lfc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import lfc_pkg::*;

    logic                 primary_valid_reg;
    logic [SLOT_W-1:0]    fallback_count_reg;

    logic                 in_full_reg;
    logic [KEY_W-1:0]     cp_reg;
    logic [MASK_W-1:0]    mask_reg;

    logic                 out_valid_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic                 hit_reg;
    logic                 evicted_reg;
    logic [KEY_W-1:0]     victim_reg;

    logic                 advance;
    logic                 cfg_clear;
    lfc_cmd_t             cmd;
    lfc_stat_t            stat [CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0] valid_vec, oldest_vec, free_vec, first_free, sel_vec;
    logic                 any_hit, full;
    logic [SLOT_W-1:0]    hit_slot, new_slot;
    logic [AGE_W-1:0]     hit_age;
    logic [KEY_W-1:0]     victim_key;

    assign advance  = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_full_reg && !advance;

    assign cfg_clear = cfg_we &&
        (cfg_index == REG_PRIMARY_VALID || cfg_index == REG_FALLBACK_COUNT);

    always_comb
    begin
        any_hit    = 1'b0;
        hit_slot   = '0;
        hit_age    = '0;
        victim_key = '0;
        for (int i = 0; i < CACHE_ENTRIES; i++)
        begin
            valid_vec[i]  = stat[i].valid;
            oldest_vec[i] = stat[i].oldest;
            any_hit    = any_hit | stat[i].match;
            hit_slot   = hit_slot | (stat[i].slot & {SLOT_W{stat[i].match}});
            hit_age    = hit_age | (stat[i].age & {AGE_W{stat[i].match}});
            victim_key = victim_key | (stat[i].key & {KEY_W{stat[i].oldest}});
        end
    end

    assign full       = &valid_vec;
    assign free_vec   = ~valid_vec;
    // isolate the lowest free entry
    assign first_free = free_vec & (~free_vec + {{(CACHE_ENTRIES-1){1'b0}}, 1'b1});
    assign sel_vec    = full ? oldest_vec : first_free;
    assign new_slot   = choose_slot(primary_valid_reg, fallback_count_reg, mask_reg);

    assign cmd.clear   = cfg_clear;
    assign cmd.upd     = advance;
    assign cmd.hit     = any_hit;
    assign cmd.hit_age = hit_age;
    assign cmd.key     = cp_reg;
    assign cmd.slot    = new_slot;

    for (genvar g = 0; g < CACHE_ENTRIES; g++)
    begin : g_entry
        lfc_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .sel   (sel_vec[g]),
            .stat  (stat[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primary_valid_reg  <= 1'b1;
            fallback_count_reg <= '0;
            in_full_reg        <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_PRIMARY_VALID)
            begin
                primary_valid_reg <= cfg_wdata[0];
            end
            if (cfg_we && cfg_index == REG_FALLBACK_COUNT)
            begin
                fallback_count_reg <= cfg_wdata[SLOT_W-1:0];
            end
            if (in_valid && !in_stall)
            begin
                in_full_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_full_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            cp_reg   <= codepoint;
            mask_reg <= support_mask;
        end
        if (advance)
        begin
            hit_reg     <= any_hit;
            slot_reg    <= any_hit ? hit_slot : new_slot;
            evicted_reg <= !any_hit && full;
            victim_reg  <= (!any_hit && full) ? victim_key : '0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign font_slot         = slot_reg;
    assign is_primary        = (slot_reg == '0);
    assign hit               = hit_reg;
    assign evicted           = evicted_reg;
    assign evicted_codepoint = victim_reg;

endmodule

// ===== sv/lfc_checker.sv =====
// port-level checks for the font choice cache, bound to the top level
// depends on lfc_pkg and lru_font_choice_cache
module lfc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [lfc_pkg::SLOT_W-1:0] font_slot,
    input logic                       is_primary,
    input logic                       hit,
    input logic                       evicted,
    input logic [lfc_pkg::KEY_W-1:0]  evicted_codepoint
);
    import lfc_pkg::*;

    // a held result word keeps its slot
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(font_slot))
        else $error("stalled result changed");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !evicted && evicted_codepoint == '0)
        else $error("hit reported an eviction");

    a_primary_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> is_primary == (font_slot == '0))
        else $error("primary flag disagrees with slot");

    a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evicted |-> evicted_codepoint == '0)
        else $error("victim key without eviction");

endmodule

bind lru_font_choice_cache lfc_checker u_lfc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .font_slot         (font_slot),
    .is_primary        (is_primary),
    .hit               (hit),
    .evicted           (evicted),
    .evicted_codepoint (evicted_codepoint)
);
